// ----- rtl/mcfe_pkg.sv -----
// Shared types, command codes, opcodes and the CRC step for the motor command frame encoder.
// No dependencies; the encoder top level imports it.
`default_nettype none

package mcfe_pkg;

  // Frame layout.
  localparam int unsigned FRAME_PAYLOAD_BYTES = 6;
  localparam int unsigned FRAME_BYTES         = 8;
  localparam int unsigned IDX_W               = $clog2(FRAME_BYTES);

  // CRC-16/Modbus.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Argument limits.
  localparam logic [31:0] MAX_SPEED_LIMIT = 32'd3000;
  localparam logic [31:0] ADDR_SET_LIMIT  = 32'd255;
  localparam logic [31:0] BRAKE_LIMIT     = 32'd10;
  localparam logic [31:0] CURVE_LIMIT     = 32'd1;
  localparam logic [7:0]  MOVE_ADDR_LIMIT = 8'd4;

  // Joint clamp limits in 1/256 degree.
  localparam logic signed [31:0] HIP_MAX_Q8  = 32'sd25600;
  localparam logic signed [31:0] HIP_MIN_Q8  = -32'sd7680;
  localparam logic signed [31:0] KNEE_MAX_Q8 = 32'sd24320;
  localparam logic signed [31:0] KNEE_MIN_Q8 = 32'sd0;

  // Joint addresses.
  localparam logic [7:0] ADDR_HIP_A  = 8'd1;
  localparam logic [7:0] ADDR_KNEE_A = 8'd2;
  localparam logic [7:0] ADDR_HIP_B  = 8'd3;
  localparam logic [7:0] ADDR_KNEE_B = 8'd4;

  // Command codes.
  typedef enum logic [4:0] {
    CMD_ENABLE      = 5'd0,
    CMD_DISABLE     = 5'd1,
    CMD_MAX_SPEED   = 5'd2,
    CMD_MOVE_ABS    = 5'd3,
    CMD_MOVE_REL    = 5'd4,
    CMD_STOP        = 5'd5,
    CMD_REAL_POS    = 5'd6,
    CMD_SET_POS     = 5'd7,
    CMD_ECHO        = 5'd8,
    CMD_MODE        = 5'd9,
    CMD_ADDR_SET    = 5'd10,
    CMD_ACCEL       = 5'd11,
    CMD_ENC_RESET   = 5'd12,
    CMD_CURRENT     = 5'd13,
    CMD_GET_SPEED   = 5'd14,
    CMD_SPEED       = 5'd15,
    CMD_CLEAR_ALERT = 5'd16,
    CMD_BRAKE       = 5'd17,
    CMD_BRAKE_QUIT  = 5'd18,
    CMD_ALERT_GET   = 5'd19,
    CMD_MOVE_STATE  = 5'd20,
    CMD_STOP_ACCEL  = 5'd21,
    CMD_CURVE       = 5'd22
  } cmd_e;

  // Drive opcodes.
  localparam logic [7:0] OP_ENABLE      = 8'h15;
  localparam logic [7:0] OP_DISABLE     = 8'h16;
  localparam logic [7:0] OP_MAX_SPEED   = 8'h2A;
  localparam logic [7:0] OP_MOVE_ABS    = 8'h28;
  localparam logic [7:0] OP_MOVE_REL    = 8'h29;
  localparam logic [7:0] OP_STOP        = 8'h3C;
  localparam logic [7:0] OP_REAL_POS    = 8'h05;
  localparam logic [7:0] OP_SET_POS     = 8'h04;
  localparam logic [7:0] OP_ECHO        = 8'h0E;
  localparam logic [7:0] OP_PARAM       = 8'h96;
  localparam logic [7:0] OP_ENC_RESET   = 8'h50;
  localparam logic [7:0] OP_CURRENT     = 8'h70;
  localparam logic [7:0] OP_GET_SPEED   = 8'h3F;
  localparam logic [7:0] OP_SPEED       = 8'h6F;
  localparam logic [7:0] OP_CLEAR_ALERT = 8'h17;
  localparam logic [7:0] OP_BRAKE       = 8'h80;
  localparam logic [7:0] OP_BRAKE_QUIT  = 8'h81;
  localparam logic [7:0] OP_ALERT_GET   = 8'h95;
  localparam logic [7:0] OP_MOVE_STATE  = 8'h64;
  localparam logic [7:0] OP_STOP_ACCEL  = 8'h96;
  localparam logic [7:0] OP_CURVE       = 8'h83;

  // Parameter register numbers carried in the payload of the 0x96 opcode, and the alert register read by 0x95.
  localparam logic [7:0] PARAM_MODE       = 8'h25;
  localparam logic [7:0] PARAM_ADDR       = 8'h0B;
  localparam logic [7:0] PARAM_ACCEL      = 8'h53;
  localparam logic [7:0] PARAM_STOP_ACCEL = 8'h58;
  localparam logic [7:0] ALERT_REG        = 8'hC8;

  // One byte of CRC-16/Modbus, bit-serial over the eight bits of the byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/motor_command_frame_encoder.sv -----
// Motor command frame encoder top level: request decode, move scaling and frame serializer.
// Depends on mcfe_pkg for command codes, opcodes, limits and the CRC step.
`default_nettype none

// Turns one command request into an 8-byte drive frame, sent as eight output
// words of one byte each: drive address, opcode, four payload bytes and the
// CRC-16/Modbus of those six bytes, low byte first, with last on the eighth.
// A request that fails its range check gives one word with accepted low, last
// high and a zero byte. The block takes one request at a time and takes its next
// request once the last word of its frame or reject is loaded. A move or speed
// command first passes the multiply stage (the 32x17 multiplier for a move
// position, a shift by 8 for a speed value) and then the shift, negate and
// saturate stage before the bytes go out. One CRC byte step runs as each of the
// six bytes ahead of the CRC is loaded into the output register, so a stalled
// output slows the frame by the stall. Configuration writes are taken in every
// cycle.
module motor_command_frame_encoder
  import mcfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel: counts per degree.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  cmd_i,
  input  wire logic [7:0]  motor_address_i,
  input  wire logic [31:0] value_i,
  input  wire logic [31:0] angle_i,
  input  wire logic        dir_i,
  // Frame byte channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_o,
  output logic             accepted_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_SEND  = 3'd3;
  localparam logic [2:0] S_REJ   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [15:0]       crc_q;
  logic [15:0]       cpd_q;
  logic [7:0]        payload_q [FRAME_PAYLOAD_BYTES];
  logic signed [31:0] operand_q;
  logic              is_speed_q;
  logic              neg_q;
  logic signed [48:0] prod_q;

  logic              out_valid_q;
  logic [7:0]        frame_byte_q;
  logic              last_q;
  logic              accepted_q;

  logic              in_fire;
  logic              out_load;

  // Decode outputs for the request being accepted.
  logic              ok_w;
  logic              scaled_w;
  logic              speed_w;
  logic [7:0]        op_w;
  logic [7:0]        p2_w, p3_w, p4_w, p5_w;
  logic signed [31:0] ang_w;

  // Scaling stage outputs.
  logic signed [40:0] shift_w;
  logic signed [41:0] signed_w;
  logic [31:0]        pos_w;

  // Byte being loaded into the output register.
  logic [7:0]        send_byte_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign last_o       = last_q;
  assign accepted_o   = accepted_q;

  // Request decode: range checks, opcode, fixed payload bytes and joint clamp.
  always_comb begin
    ok_w     = 1'b1;
    scaled_w = 1'b0;
    speed_w  = 1'b0;
    op_w     = 8'h00;
    p2_w     = 8'h00;
    p3_w     = 8'h00;
    p4_w     = 8'h00;
    p5_w     = 8'h00;
    ang_w    = $signed(angle_i);
    unique case (cmd_i)
      CMD_ENABLE:      op_w = OP_ENABLE;
      CMD_DISABLE:     op_w = OP_DISABLE;
      CMD_MAX_SPEED: begin
        ok_w = !value_i[31] && (value_i <= MAX_SPEED_LIMIT);
        op_w = OP_MAX_SPEED;
        p2_w = value_i[15:8];
        p3_w = value_i[7:0];
      end
      CMD_MOVE_ABS, CMD_MOVE_REL: begin
        ok_w     = (motor_address_i <= MOVE_ADDR_LIMIT);
        scaled_w = 1'b1;
        op_w     = (cmd_i == CMD_MOVE_ABS) ? OP_MOVE_ABS : OP_MOVE_REL;
        if (cmd_i == CMD_MOVE_ABS &&
            (motor_address_i == ADDR_HIP_A || motor_address_i == ADDR_HIP_B)) begin
          if (ang_w > HIP_MAX_Q8) begin
            ang_w = HIP_MAX_Q8;
          end else if (ang_w < HIP_MIN_Q8) begin
            ang_w = HIP_MIN_Q8;
          end
        end
        if (cmd_i == CMD_MOVE_ABS &&
            (motor_address_i == ADDR_KNEE_A || motor_address_i == ADDR_KNEE_B)) begin
          if (ang_w < KNEE_MIN_Q8) begin
            ang_w = KNEE_MIN_Q8;
          end else if (ang_w > KNEE_MAX_Q8) begin
            ang_w = KNEE_MAX_Q8;
          end
        end
      end
      CMD_STOP:        op_w = OP_STOP;
      CMD_REAL_POS:    op_w = OP_REAL_POS;
      CMD_SET_POS:     op_w = OP_SET_POS;
      CMD_ECHO:        op_w = OP_ECHO;
      CMD_MODE: begin
        op_w = OP_PARAM;
        p3_w = PARAM_MODE;
        p5_w = value_i[7:0];
      end
      CMD_ADDR_SET: begin
        ok_w = !value_i[31] && (value_i <= ADDR_SET_LIMIT);
        op_w = OP_PARAM;
        p3_w = PARAM_ADDR;
        p5_w = value_i[7:0];
      end
      CMD_ACCEL: begin
        op_w = OP_PARAM;
        p3_w = PARAM_ACCEL;
        p4_w = value_i[15:8];
        p5_w = value_i[7:0];
      end
      CMD_ENC_RESET:   op_w = OP_ENC_RESET;
      CMD_CURRENT: begin
        op_w = OP_CURRENT;
        p2_w = value_i[15:8];
        p3_w = value_i[7:0];
      end
      CMD_GET_SPEED:   op_w = OP_GET_SPEED;
      CMD_SPEED: begin
        scaled_w = 1'b1;
        speed_w  = 1'b1;
        op_w     = OP_SPEED;
      end
      CMD_CLEAR_ALERT: op_w = OP_CLEAR_ALERT;
      CMD_BRAKE: begin
        ok_w = !value_i[31] && (value_i <= BRAKE_LIMIT);
        op_w = OP_BRAKE;
        p2_w = value_i[15:8];
        p3_w = value_i[7:0];
      end
      CMD_BRAKE_QUIT:  op_w = OP_BRAKE_QUIT;
      CMD_ALERT_GET: begin
        op_w = OP_ALERT_GET;
        p3_w = ALERT_REG;
      end
      CMD_MOVE_STATE:  op_w = OP_MOVE_STATE;
      CMD_STOP_ACCEL: begin
        op_w = OP_STOP_ACCEL;
        p3_w = PARAM_STOP_ACCEL;
        p4_w = value_i[15:8];
        p5_w = value_i[7:0];
      end
      CMD_CURVE: begin
        ok_w = !value_i[31] && (value_i <= CURVE_LIMIT);
        op_w = OP_CURVE;
        p3_w = value_i[7:0];
      end
      default:         ok_w = 1'b0;
    endcase
  end

  // Floor by 256 is an arithmetic shift; then negate and saturate to 32 bits.
  assign shift_w  = prod_q[48:8];
  assign signed_w = neg_q ? -{shift_w[40], shift_w} : {shift_w[40], shift_w};
  always_comb begin
    if (signed_w[41:31] != {11{signed_w[41]}}) begin
      pos_w = signed_w[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      pos_w = signed_w[31:0];
    end
  end

  // Frame byte selection: six stored bytes, then CRC low and high.
  always_comb begin
    if (idx_q < IDX_W'(FRAME_PAYLOAD_BYTES)) begin
      send_byte_w = payload_q[idx_q];
    end else if (idx_q == IDX_W'(FRAME_PAYLOAD_BYTES)) begin
      send_byte_w = crc_q[7:0];
    end else begin
      send_byte_w = crc_q[15:8];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!ok_w) begin
            state_d = S_REJ;
          end else if (scaled_w) begin
            state_d = S_MUL;
          end else begin
            state_d = S_SEND;
          end
        end
      end
      S_MUL:   state_d = S_SCALE;
      S_SCALE: state_d = S_SEND;
      S_SEND: begin
        if (out_load && idx_q == IDX_W'(FRAME_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_REJ: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
      cpd_q       <= 16'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cpd_q <= cfg_data_i;
      end
      if (in_fire && ok_w) begin
        idx_q <= '0;
        crc_q <= CRC_INIT;
      end else if (state_q == S_SEND && out_load) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q < IDX_W'(FRAME_PAYLOAD_BYTES)) begin
          crc_q <= crc_byte(crc_q, send_byte_w);
        end
      end
      if ((state_q == S_SEND || state_q == S_REJ) && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, operand and multiplier registers.
  always_ff @(posedge clk_i) begin
    if (in_fire && ok_w) begin
      payload_q[0] <= motor_address_i;
      payload_q[1] <= op_w;
      payload_q[2] <= p2_w;
      payload_q[3] <= p3_w;
      payload_q[4] <= p4_w;
      payload_q[5] <= p5_w;
      operand_q    <= speed_w ? $signed(value_i) : ang_w;
      is_speed_q   <= speed_w;
      neg_q        <= !dir_i;
    end
    if (state_q == S_MUL) begin
      if (is_speed_q) begin
        prod_q <= {{9{operand_q[31]}}, operand_q, 8'h00};
      end else begin
        prod_q <= operand_q * $signed({1'b0, cpd_q});
      end
    end
    if (state_q == S_SCALE) begin
      payload_q[2] <= pos_w[31:24];
      payload_q[3] <= pos_w[23:16];
      payload_q[4] <= pos_w[15:8];
      payload_q[5] <= pos_w[7:0];
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_SEND && out_load) begin
      frame_byte_q <= send_byte_w;
      last_q       <= (idx_q == IDX_W'(FRAME_BYTES - 1));
      accepted_q   <= 1'b1;
    end else if (state_q == S_REJ && out_load) begin
      frame_byte_q <= 8'h00;
      last_q       <= 1'b1;
      accepted_q   <= 1'b0;
    end
  end

  // A reject word is always a lone, zero, last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> last_o && frame_byte_o == 8'h00)
    else $error("reject word is not a zero last word");

  // No request is taken while a frame or reject is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while busy");

  // Loading the final frame byte returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEND && out_load && idx_q == IDX_W'(FRAME_BYTES - 1) |=>
      state_q == S_IDLE && last_o && accepted_o)
    else $error("frame did not close after its last byte");

  // The seventh byte carries the CRC low byte over the six frame bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEND && out_load && idx_q == IDX_W'(FRAME_PAYLOAD_BYTES) |=>
      frame_byte_o == $past(crc_q[7:0]) && !last_o)
    else $error("CRC low byte mismatch");

endmodule

`default_nettype wire
